[hdl/pcft_pkg.sv]
// Package for the pub/sub channel fan-out table.
// Holds the word types, command and role codes, controller states and the
// command/status structs between the controller and the datapath.
package pcft_pkg;

	localparam int MAX_CLIENTS_DEF  = 16;
	localparam int NUM_CHANNELS_DEF = 256;
	localparam int ADDR_W           = 48;
	localparam int CH_FIELD_W       = 8;

	typedef enum logic [2:0] {
		CMD_EXIT      = 3'd0,
		CMD_PUB       = 3'd1,
		CMD_SUB_ALL   = 3'd2,
		CMD_SUB_START = 3'd3,
		CMD_SUB_MORE  = 3'd4,
		CMD_MSG       = 3'd5,
		CMD_OTHER     = 3'd6
	} cmd_t;

	localparam logic [1:0] ROLE_PUB = 2'd1;
	localparam logic [1:0] ROLE_SUB = 2'd2;

	localparam logic STATUS_DELIVER = 1'b0;
	localparam logic STATUS_FULL    = 1'b1;

	typedef struct packed {
		logic [2:0]            command;
		logic [31:0]           sender_ip;
		logic [15:0]           sender_port;
		logic [CH_FIELD_W-1:0] channel;
		logic                  channel_present;
	} dgram_t;

	typedef struct packed {
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic        status;
		logic        last;
	} dest_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEARCH,
		S_DISPATCH,
		S_FULL,
		S_CNT,
		S_CAP,
		S_APP,
		S_SCAN,
		S_CHK,
		S_XEND,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_ALL,
		OP_ONE,
		OP_DUP,
		OP_EXIT,
		OP_ROUTE
	} op_t;

	typedef struct packed {
		logic load_item;
		logic search_step;
		logic alloc;
		logic set_open;
		logic set_keep;
		logic clr_entry;
		logic ch_load;
		logic ch_clr;
		logic ch_inc;
		logic cnt_cap;
		logic i_inc;
		logic app_wr;
		logic x_copy;
		logic x_cnt_wr;
		logic route_take;
		logic flush;
		logic full_emit;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic found;
		logic free_found;
		logic role_pub;
		logic role_sub;
		logic present;
		logic ch_in_range;
		logic open_match;
		logic k_last;
		logic ch_last;
		logic ch_zero;
		logic i_eq_cnt;
		logic cnt_full;
		logic list_is_e;
		logic list_skip;
		logic pend_valid;
		logic out_ok;
	} dp_stat_t;

endpackage

[hdl/pcft_stream_if.sv]
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is set per instance; no package dependency.
interface pcft_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[hdl/pcft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[hdl/pcft_dp.sv]
// Datapath: client table, per-channel subscriber lists and counts, scan
// counters, pending result and output register. Uses pcft_pkg and pcft_ram.
module pcft_dp #(
	parameter int MAX_CLIENTS  = pcft_pkg::MAX_CLIENTS_DEF,
	parameter int NUM_CHANNELS = pcft_pkg::NUM_CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pcft_pkg::dgram_t   item,
	input  pcft_pkg::dp_cmd_t  cmd,
	output pcft_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output pcft_pkg::dest_t    out_word
);
	import pcft_pkg::*;

	localparam int EW     = $clog2(MAX_CLIENTS);
	localparam int CW     = $clog2(MAX_CLIENTS + 1);
	localparam int CHW    = $clog2(NUM_CHANNELS);
	localparam int LDEPTH = NUM_CHANNELS * (2 ** EW);

	logic [2:0]            cmd_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [CH_FIELD_W-1:0] ch_in_q;
	logic                  present_q;

	logic [MAX_CLIENTS-1:0] valid_q;
	logic [ADDR_W-1:0]      tbl_addr_q [MAX_CLIENTS];
	logic [1:0]             tbl_role_q [MAX_CLIENTS];

	logic [EW-1:0]  k_q, e_q, free_q, open_e_q;
	logic [1:0]     role_q;
	logic           found_q, free_found_q, keep_q, open_valid_q;
	logic [CHW-1:0] ch_q;
	logic [CW-1:0]  cnt_q, i_q, j_q;

	logic [NUM_CHANNELS-1:0] cvalid_q;
	logic                    cvalid_s1;
	logic [CW-1:0]           cnt_rdata, cnt_rd;
	logic [EW-1:0]           list_rd;

	logic              pend_valid_q;
	logic [ADDR_W-1:0] pend_q;
	logic              out_valid_q;
	dest_t             out_q;

	logic [EW-1:0]     tbl_idx;
	logic [ADDR_W-1:0] tbl_rd;
	logic              hit, out_ok, list_is_e;

	assign tbl_idx   = cmd.search_step ? k_q : list_rd;
	assign tbl_rd    = tbl_addr_q[tbl_idx];
	assign hit       = valid_q[tbl_idx] && (tbl_rd == addr_q);
	assign out_ok    = !out_valid_q || out_ready;
	assign cnt_rd    = cvalid_s1 ? cnt_rdata : '0;
	assign list_is_e = (list_rd == e_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			keep_q       <= 1'b0;
			open_valid_q <= 1'b0;
			k_q          <= '0;
			ch_q         <= '0;
			cnt_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			cvalid_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				k_q          <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				keep_q       <= 1'b0;
			end
			if (cmd.search_step) begin
				k_q <= k_q + 1'b1;
				if (hit) begin
					found_q <= 1'b1;
				end
				if (!valid_q[k_q]) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.alloc) begin
				valid_q[free_q] <= 1'b1;
			end
			if (cmd.clr_entry) begin
				valid_q[e_q] <= 1'b0;
			end
			if (cmd.set_keep) begin
				keep_q <= 1'b1;
			end
			if (cmd.finish) begin
				open_valid_q <= keep_q;
			end
			if (cmd.ch_load) begin
				ch_q <= ch_in_q[CHW-1:0];
			end else if (cmd.ch_clr) begin
				ch_q <= '0;
			end else if (cmd.ch_inc) begin
				ch_q <= ch_q + 1'b1;
			end
			if (cmd.cnt_cap) begin
				cnt_q <= cnt_rd;
				i_q   <= '0;
				j_q   <= '0;
			end
			if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.x_copy) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.app_wr || cmd.x_cnt_wr) begin
				cvalid_q[ch_q] <= 1'b1;
			end
			if (cmd.route_take) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if ((cmd.route_take && pend_valid_q) || cmd.flush || cmd.full_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cvalid_s1 <= cvalid_q[ch_q];
		if (cmd.load_item) begin
			cmd_q     <= item.command;
			addr_q    <= {item.sender_ip, item.sender_port};
			ch_in_q   <= item.channel;
			present_q <= item.channel_present;
		end
		if (cmd.search_step && hit && !found_q) begin
			e_q    <= k_q;
			role_q <= tbl_role_q[tbl_idx];
		end
		if (cmd.search_step && !valid_q[k_q] && !free_found_q) begin
			free_q <= k_q;
		end
		if (cmd.alloc) begin
			tbl_addr_q[free_q] <= addr_q;
			tbl_role_q[free_q] <= (cmd_q == CMD_PUB) ? ROLE_PUB : ROLE_SUB;
			e_q                <= free_q;
		end
		if (cmd.set_open) begin
			open_e_q <= free_q;
		end
		if (cmd.route_take) begin
			pend_q <= tbl_rd;
		end
		if (cmd.full_emit) begin
			out_q <= '{dest_ip: addr_q[47:16], dest_port: addr_q[15:0],
				status: STATUS_FULL, last: 1'b1};
		end else if (cmd.flush) begin
			out_q <= '{dest_ip: pend_q[47:16], dest_port: pend_q[15:0],
				status: STATUS_DELIVER, last: 1'b1};
		end else if (cmd.route_take && pend_valid_q) begin
			out_q <= '{dest_ip: pend_q[47:16], dest_port: pend_q[15:0],
				status: STATUS_DELIVER, last: 1'b0};
		end
	end

	pcft_ram #(.WIDTH(CW), .DEPTH(NUM_CHANNELS)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.app_wr || cmd.x_cnt_wr),
		.waddr (ch_q),
		.wdata (cmd.app_wr ? cnt_q + CW'(1) : j_q),
		.raddr (ch_q),
		.rdata (cnt_rdata)
	);

	pcft_ram #(.WIDTH(EW), .DEPTH(LDEPTH)) u_list_ram (
		.clk   (clk),
		.we    (cmd.app_wr || cmd.x_copy),
		.waddr ({ch_q, cmd.app_wr ? cnt_q[EW-1:0] : j_q[EW-1:0]}),
		.wdata (cmd.app_wr ? e_q : list_rd),
		.raddr ({ch_q, i_q[EW-1:0]}),
		.rdata (list_rd)
	);

	always_comb begin
		stat.cmd         = cmd_t'(cmd_q);
		stat.found       = found_q;
		stat.free_found  = free_found_q;
		stat.role_pub    = (role_q == ROLE_PUB);
		stat.role_sub    = (role_q == ROLE_SUB);
		stat.present     = present_q;
		stat.ch_in_range = ({1'b0, ch_in_q} < (CH_FIELD_W + 1)'(NUM_CHANNELS));
		stat.open_match  = open_valid_q && (open_e_q == e_q);
		stat.k_last      = (k_q == EW'(MAX_CLIENTS - 1));
		stat.ch_last     = (ch_q == CHW'(NUM_CHANNELS - 1));
		stat.ch_zero     = (ch_q == '0);
		stat.i_eq_cnt    = (i_q == cnt_q);
		stat.cnt_full    = (cnt_q == CW'(MAX_CLIENTS));
		stat.list_is_e   = list_is_e;
		stat.list_skip   = list_is_e || ({1'b0, list_rd} >= (EW + 1)'(MAX_CLIENTS));
		stat.pend_valid  = pend_valid_q;
		stat.out_ok      = out_ok;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_alloc_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> valid_q[e_q])
		else $error("allocated entry not marked valid");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_CLIENTS))
		else $error("subscriber count above table size");
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !pend_valid_q)
		else $error("pending destination left after item end");
	a_full_only_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.full_emit |-> !free_found_q && !found_q)
		else $error("table full word with free entry or known sender");
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.app_wr |-> cnt_q < CW'(MAX_CLIENTS))
		else $error("append into a full subscriber list");
endmodule

[hdl/pcft_ctrl.sv]
// Controller state machine: sequences search, allocation, list walks and
// result emission through dp_cmd_t / dp_stat_t. Uses pcft_pkg.
module pcft_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pcft_pkg::dp_stat_t stat,
	output pcft_pkg::dp_cmd_t  cmd
);
	import pcft_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_ALL;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (stat.k_last) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FINISH;
				unique case (stat.cmd) inside
					CMD_EXIT: begin
						if (stat.found && stat.role_sub) begin
							op_d    = OP_EXIT;
							state_d = S_CNT;
						end
					end
					CMD_PUB, CMD_SUB_ALL, CMD_SUB_START: begin
						if (!stat.found) begin
							if (!stat.free_found) begin
								state_d = S_FULL;
							end else if (stat.cmd == CMD_SUB_ALL) begin
								op_d    = OP_ALL;
								state_d = S_CNT;
							end else if (stat.cmd == CMD_SUB_START && stat.present
								&& stat.ch_in_range) begin
								op_d    = OP_ONE;
								state_d = S_CNT;
							end
						end
					end
					CMD_SUB_MORE: begin
						if (stat.found && stat.open_match && stat.ch_in_range) begin
							op_d    = OP_DUP;
							state_d = S_CNT;
						end
					end
					CMD_MSG: begin
						if (stat.found && stat.role_pub && stat.ch_in_range) begin
							op_d    = OP_ROUTE;
							state_d = S_CNT;
						end
					end
					default: ;
				endcase
			end
			S_FULL: begin
				if (stat.out_ok) state_d = S_FINISH;
			end
			S_CNT: state_d = S_CAP;
			S_CAP: begin
				state_d = (op_q == OP_ALL || op_q == OP_ONE) ? S_APP : S_SCAN;
			end
			S_APP: begin
				state_d = (op_q == OP_ALL && !stat.ch_last) ? S_CNT : S_FINISH;
			end
			S_SCAN: begin
				if (stat.i_eq_cnt) begin
					case (op_q)
						OP_DUP:   state_d = S_APP;
						OP_EXIT:  state_d = S_XEND;
						OP_ROUTE: state_d = stat.ch_zero ? S_FINISH : S_CNT;
						default:  state_d = S_FINISH;
					endcase
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				case (op_q)
					OP_DUP:   state_d = stat.list_is_e ? S_FINISH : S_SCAN;
					OP_EXIT:  state_d = S_SCAN;
					OP_ROUTE: begin
						if (stat.list_skip || !stat.pend_valid || stat.out_ok) state_d = S_SCAN;
					end
					default:  state_d = S_FINISH;
				endcase
			end
			S_XEND: state_d = stat.ch_last ? S_FINISH : S_CNT;
			S_FINISH: begin
				if (!stat.pend_valid || stat.out_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			S_SEARCH: cmd.search_step = 1'b1;
			S_DISPATCH: begin
				unique case (stat.cmd) inside
					CMD_EXIT: begin
						if (stat.found) begin
							if (stat.role_sub) cmd.ch_clr = 1'b1;
							else cmd.clr_entry = 1'b1;
						end
					end
					CMD_PUB, CMD_SUB_ALL, CMD_SUB_START: begin
						if (!stat.found && stat.free_found) begin
							cmd.alloc = 1'b1;
							if (stat.cmd == CMD_SUB_ALL) cmd.ch_clr = 1'b1;
							if (stat.cmd == CMD_SUB_START && stat.present) begin
								cmd.set_open = 1'b1;
								cmd.set_keep = 1'b1;
								cmd.ch_load  = stat.ch_in_range;
							end
						end
					end
					CMD_SUB_MORE: begin
						if (stat.found && stat.open_match) begin
							cmd.set_keep = 1'b1;
							cmd.ch_load  = stat.ch_in_range;
						end
					end
					CMD_MSG: begin
						cmd.ch_load = stat.found && stat.role_pub && stat.ch_in_range;
					end
					default: ;
				endcase
			end
			S_FULL: cmd.full_emit = stat.out_ok;
			S_CNT: ;
			S_CAP: cmd.cnt_cap = 1'b1;
			S_APP: begin
				cmd.app_wr = !stat.cnt_full;
				cmd.ch_inc = (op_q == OP_ALL) && !stat.ch_last;
			end
			S_SCAN: begin
				cmd.ch_clr = stat.i_eq_cnt && (op_q == OP_ROUTE) && !stat.ch_zero;
			end
			S_CHK: begin
				case (op_q)
					OP_DUP: cmd.i_inc = !stat.list_is_e;
					OP_EXIT: begin
						cmd.x_copy = !stat.list_is_e;
						cmd.i_inc  = 1'b1;
					end
					OP_ROUTE: begin
						if (stat.list_skip) begin
							cmd.i_inc = 1'b1;
						end else if (!stat.pend_valid || stat.out_ok) begin
							cmd.route_take = 1'b1;
							cmd.i_inc      = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_XEND: begin
				cmd.x_cnt_wr  = 1'b1;
				cmd.ch_inc    = !stat.ch_last;
				cmd.clr_entry = stat.ch_last;
			end
			S_FINISH: begin
				if (!stat.pend_valid || stat.out_ok) begin
					cmd.flush  = stat.pend_valid;
					cmd.finish = 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

[hdl/pubsub_channel_fanout_table_unit.sv]
// Top level of the pub/sub channel fan-out table: controller plus datapath.
// Uses pcft_pkg, pcft_stream_if, pcft_ctrl and pcft_dp.
//
// dgram (sink, dgram_t words): one classified datagram per word. dest
// (source, dest_t words): destination addresses of a message, or one word
// with status 1 when a new client finds the table full; last marks the
// final word caused by a datagram. Most datagrams cause no word.
// One datagram is worked at a time. Every datagram first scans the client
// table, one entry per cycle, then dispatches. A message then walks its
// channel's list and, for a nonzero channel, the list of channel 0. A sub
// list item that checks for duplicates walks the channel's list first.
// Subscribe-all visits every channel through the count and list RAMs, and
// so does the exit of a subscriber, which also walks each channel's list.
// Reset empties the client table, zeroes all counts through per-channel
// valid flags and closes any open list; no clearing pass is needed.
// When dest stalls, one word waits in the output register and the next in
// a pending register; the walk holds until the output drains.
module pubsub_channel_fanout_table_unit #(
	parameter int MAX_CLIENTS  = pcft_pkg::MAX_CLIENTS_DEF,
	parameter int NUM_CHANNELS = pcft_pkg::NUM_CHANNELS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	pcft_stream_if.sink   dgram,
	pcft_stream_if.source dest
);
	import pcft_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	pcft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dgram.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign dgram.ready = in_ready;

	pcft_dp #(
		.MAX_CLIENTS  (MAX_CLIENTS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (dgram.payload),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (dest.valid),
		.out_ready (dest.ready),
		.out_word  (dest.payload)
	);
endmodule

[dv/pcft_scoreboard.sv]
// Scoreboard class for the pub/sub channel fan-out table testbench.
// Predicts destination words from accepted datagrams; depends on pcft_pkg.
class pcft_scoreboard;
	bit                 used [16];
	logic [47:0]        addr_of [16];
	logic [1:0]         role_of [16];
	bit                 subbed [256][16];
	int unsigned        members [256][$];
	bit                 list_open;
	int unsigned        list_owner;
	pcft_pkg::dest_t    pending [$];
	int unsigned        errors;
	int unsigned        words_seen;

	function new();
		foreach (used[i]) used[i] = 0;
		foreach (members[c]) members[c].delete();
		foreach (subbed[c, i]) subbed[c][i] = 0;
		list_open = 0;
		list_owner = 0;
		errors = 0;
		words_seen = 0;
	endfunction

	function void join_channel(int unsigned e, int unsigned ch);
		if (subbed[ch][e] || members[ch].size() >= 16) return;
		subbed[ch][e] = 1;
		members[ch] = {members[ch], e};
	endfunction

	function void emit_dest(logic [47:0] a, logic st, ref pcft_pkg::dest_t outs[$]);
		pcft_pkg::dest_t d;
		d.dest_ip = a[47:16];
		d.dest_port = a[15:0];
		d.status = st;
		d.last = 0;
		outs = {outs, d};
	endfunction

	function void walk_list(int unsigned ch, int unsigned src, ref pcft_pkg::dest_t outs[$]);
		for (int k = 0; k < members[ch].size(); k++)
			if (members[ch][k] != src)
				emit_dest(addr_of[members[ch][k]], pcft_pkg::STATUS_DELIVER, outs);
	endfunction

	function void note_dgram(pcft_pkg::dgram_t g);
		logic [47:0]      a;
		bit               known;
		bit               keep;
		int unsigned      e;
		int               slot;
		pcft_pkg::dest_t  outs [$];
		a = {g.sender_ip, g.sender_port};
		known = 0;
		keep = 0;
		e = 0;
		slot = -1;
		for (int i = 0; i < 16; i++)
			if (used[i] && addr_of[i] == a && !known) begin
				known = 1;
				e = i;
			end
		case (g.command)
			pcft_pkg::CMD_EXIT: if (known) begin
				for (int c = 0; c < 256; c++) begin
					if (role_of[e] == pcft_pkg::ROLE_SUB && subbed[c][e]) begin
						for (int k = members[c].size() - 1; k >= 0; k--)
							if (members[c][k] == e) members[c].delete(k);
					end
					subbed[c][e] = 0;
				end
				used[e] = 0;
			end
			pcft_pkg::CMD_PUB, pcft_pkg::CMD_SUB_ALL, pcft_pkg::CMD_SUB_START: if (!known) begin
				for (int i = 15; i >= 0; i--) if (!used[i]) slot = i;
				if (slot < 0) emit_dest(a, pcft_pkg::STATUS_FULL, outs);
				else begin
					e = slot;
					used[e] = 1;
					addr_of[e] = a;
					for (int c = 0; c < 256; c++) subbed[c][e] = 0;
					if (g.command == pcft_pkg::CMD_PUB) role_of[e] = pcft_pkg::ROLE_PUB;
					else begin
						role_of[e] = pcft_pkg::ROLE_SUB;
						if (g.command == pcft_pkg::CMD_SUB_ALL) begin
							for (int c = 0; c < 256; c++) join_channel(e, c);
						end else if (g.channel_present) begin
							join_channel(e, g.channel);
							keep = 1;
							list_owner = e;
						end
					end
				end
			end
			pcft_pkg::CMD_SUB_MORE: if (known && list_open && list_owner == e) begin
				join_channel(e, g.channel);
				keep = 1;
			end
			pcft_pkg::CMD_MSG: if (known && role_of[e] == pcft_pkg::ROLE_PUB) begin
				walk_list(g.channel, e, outs);
				if (g.channel != 0) walk_list(0, e, outs);
			end
			default: ;
		endcase
		list_open = keep;
		if (outs.size() > 0) outs[outs.size() - 1].last = 1;
		pending = {pending, outs};
	endfunction

	function void check_dest(pcft_pkg::dest_t got);
		pcft_pkg::dest_t want;
		words_seen++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected word %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display({"mismatch: exp ip %h port %h st %b last %b,",
					" got ip %h port %h st %b last %b"},
					want.dest_ip, want.dest_port, want.status, want.last,
					got.dest_ip, got.dest_port, got.status, got.last);
		end
	endfunction
endclass

[dv/tb.sv]
// Testbench top for pubsub_channel_fanout_table_unit.
// Depends on pcft_pkg, pcft_stream_if and pcft_scoreboard; drives datagrams
// with bursty gaps, stalls the dest side and checks every word.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcft_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	pcft_stream_if #(.payload_t(dgram_t)) dgram ();
	pcft_stream_if #(.payload_t(dest_t))  dest ();

	pubsub_channel_fanout_table_unit dut (.clk(clk), .arst_n(arst_n), .dgram(dgram), .dest(dest));

	pcft_scoreboard fanout = new();
	logic [47:0] known_addrs [$];
	bit hold_dest = 0;
	bit all_sent = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (dgram.valid && dgram.ready) fanout.note_dgram(dgram.payload);
		if (dest.valid && dest.ready) fanout.check_dest(dest.payload);
		if ((dgram.valid && dgram.ready) || (dest.valid && dest.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) if (idle_cycles >= IDLE_LIMIT) begin
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		dest.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_dest) dest.ready <= 0;
			else case ($urandom_range(3))
				0: dest.ready <= ($urandom_range(3) == 0);
				1: dest.ready <= 1;
				default: dest.ready <= ($urandom_range(1) == 0);
			endcase
		end
	end

	task automatic send_word(logic [2:0] cmd, logic [47:0] a, logic [7:0] ch, logic pres);
		dgram_t g;
		g.command = cmd;
		g.sender_ip = a[47:16];
		g.sender_port = a[15:0];
		g.channel = ch;
		g.channel_present = pres;
		dgram.valid <= 1;
		dgram.payload <= g;
		@(posedge clk);
		while (!dgram.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		dgram.valid <= 0;
		repeat ($urandom_range(6)) @(negedge clk);
	endtask

	function automatic logic [47:0] pick_addr();
		if (known_addrs.size() > 0 && $urandom_range(7) != 0)
			return known_addrs[$urandom_range(known_addrs.size() - 1)];
		return {$urandom(), 16'($urandom())};
	endfunction

	function automatic logic [7:0] pick_ch();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'($urandom_range(3));
			2: return 8'd255;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic drain();
		dgram.valid <= 0;
		while (fanout.pending.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
	endtask

	task automatic random_word();
		logic [47:0] a;
		logic [2:0]  cmd;
		int r;
		r = $urandom_range(99);
		a = pick_addr();
		if (r < 12) begin
			a = {$urandom(), 16'($urandom())};
			known_addrs = {known_addrs, a};
			cmd = CMD_SUB_START;
		end else if (r < 18) begin
			a = {$urandom(), 16'($urandom())};
			known_addrs = {known_addrs, a};
			cmd = CMD_PUB;
		end else if (r < 20) begin
			a = {$urandom(), 16'($urandom())};
			known_addrs = {known_addrs, a};
			cmd = CMD_SUB_ALL;
		end else if (r < 40) cmd = CMD_SUB_MORE;
		else if (r < 75) cmd = CMD_MSG;
		else if (r < 83) cmd = CMD_EXIT;
		else cmd = 3'($urandom_range(7));
		send_word(cmd, a, pick_ch(), 1'($urandom()));
		if (cmd == CMD_SUB_ALL || (cmd == CMD_EXIT && $urandom_range(3) == 0)) drain();
	endtask

	initial begin
		logic [47:0] p0, s0;
		dgram.valid = 0;
		dgram.payload = '0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		p0 = 48'hFFFF_FFFF_FFFF;
		s0 = 48'h0;
		send_word(CMD_MSG, p0, 8'd1, 1'b0);
		send_word(CMD_SUB_MORE, s0, 8'd1, 1'b1);
		send_word(CMD_PUB, p0, 8'd7, 1'b1);
		send_word(CMD_SUB_START, s0, 8'd0, 1'b1);
		send_word(CMD_SUB_MORE, s0, 8'd255, 1'b1);
		send_word(CMD_SUB_MORE, s0, 8'd255, 1'b1);
		send_word(CMD_SUB_START, 48'h0A00_0001_1234, 8'd5, 1'b0);
		send_word(CMD_SUB_MORE, 48'h0A00_0001_1234, 8'd5, 1'b1);
		send_word(CMD_SUB_ALL, 48'h5555_AAAA_5A5A, 8'd0, 1'b0);
		drain();
		send_word(CMD_PUB, s0, 8'd0, 1'b0);
		send_word(CMD_MSG, p0, 8'd255, 1'b0);
		send_word(CMD_MSG, p0, 8'd0, 1'b0);
		send_word(CMD_MSG, p0, 8'd5, 1'b0);
		send_word(CMD_MSG, s0, 8'd0, 1'b0);
		send_word(CMD_OTHER, p0, 8'd0, 1'b0);
		send_word(3'd7, p0, 8'd0, 1'b0);
		send_word(CMD_EXIT, 48'h1234_5678_9ABC, 8'd0, 1'b0);
		send_word(CMD_EXIT, s0, 8'd0, 1'b0);
		drain();
		for (int i = 0; i < 16; i++) send_word(CMD_SUB_START, {32'hC0A8_0000 + i, 16'hF000}, 8'd9, 1'b1);
		send_word(CMD_MSG, p0, 8'd9, 1'b0);
		send_word(CMD_EXIT, 48'h5555_AAAA_5A5A, 8'd0, 1'b0);
		drain();
		fork
			begin
				hold_dest = 1;
				repeat (600) @(negedge clk);
				hold_dest = 0;
			end
		join_none
		for (int i = 0; i < 4; i++) send_word(CMD_MSG, p0, 8'd9, 1'b0);
		dgram.valid <= 0;
		wait (!hold_dest);
		@(negedge clk);
		for (int i = 0; i < 16; i++) begin
			send_word(CMD_EXIT, {32'hC0A8_0000 + i, 16'hF000}, 8'd0, 1'b0);
			drain();
		end
		send_word(CMD_EXIT, p0, 8'd0, 1'b0);
		send_word(CMD_EXIT, 48'h0A00_0001_1234, 8'd0, 1'b0);
		drain();
		for (int n = 0; n < 352;) begin
			for (int b = $urandom_range(1, 12); b > 0 && n < 352; b--, n++) random_word();
			if ($urandom_range(2) == 0) gap();
			if (known_addrs.size() > 40) known_addrs.delete(0);
		end
		dgram.valid <= 0;
		while (fanout.pending.size() != 0) @(negedge clk);
		repeat (1200) @(negedge clk);
		if (fanout.errors == 0 && fanout.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

[filelist.f]
hdl/pcft_pkg.sv
hdl/pcft_stream_if.sv
hdl/pcft_ram.sv
hdl/pcft_dp.sv
hdl/pcft_ctrl.sv
hdl/pubsub_channel_fanout_table_unit.sv
dv/pcft_scoreboard.sv
dv/tb.sv
